/* rtl/core/b64_pkg.sv */
// shared types, character codes and alphabet functions for the base64 codec
`default_nettype none

package b64_pkg;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam int JOB_MAX_BYTES = 4;

    // one classified item: up to four result bytes sharing one status
    typedef struct packed {
        logic [JOB_MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                    count;
        logic [1:0]                    status;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic variant);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)
            return 8'h41 + v8;
        else if (v < 6'd52)
            return 8'h61 + (v8 - 8'd26);
        else if (v < 6'd62)
            return 8'h30 + (v8 - 8'd52);
        else if (v == 6'd62)
            return variant ? 8'h2D : 8'h2B;
        else
            return variant ? 8'h5F : 8'h2F;
    endfunction

    // 0..63 for a character in the alphabet, 64 otherwise
    function automatic logic [6:0] char_sextet(input logic [7:0] c, input logic variant);
        logic [7:0] c62;
        logic [7:0] c63;
        c62 = variant ? 8'h2D : 8'h2B;
        c63 = variant ? 8'h5F : 8'h2F;
        if (c >= 8'h41 && c <= 8'h5A)
            return 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            return 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            return 7'(c - 8'h30 + 8'd52);
        else if (c == c62)
            return 7'd62;
        else if (c == c63)
            return 7'd63;
        else
            return 7'd64;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/b64_item_if.sv */
// input item channel of the base64 codec
`default_nettype none

interface b64_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       last_item;

    modport source (output valid, action, data_byte, last_item, input ready);
    modport sink   (input valid, action, data_byte, last_item, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64_result_if.sv */
// result channel of the base64 codec
`default_nettype none

interface b64_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic [1:0] status;

    modport source (output valid, out_byte, run_last, status, input ready);
    modport sink   (input valid, out_byte, run_last, status, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64_cfg_if.sv */
// configuration write channel of the base64 codec
`default_nettype none

interface b64_cfg_if;
    logic valid;
    logic ready;
    logic alphabet_variant;

    modport source (output valid, alphabet_variant, input ready);
    modport sink   (input valid, alphabet_variant, output ready);
endinterface

`default_nettype wire

/* rtl/core/b64_front.sv */
// front end: accepts items, keeps group state and builds result jobs
`default_nettype none

module b64_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        alphabet_variant,
    input  wire logic        q_full,
    b64_item_if.sink         item,
    output b64_pkg::job_t    job,
    output logic             job_push
);

    logic [23:0] gb_reg, gb_next;
    logic [1:0]  gc_reg, gc_next;
    logic        pad_reg, pad_next;
    logic [1:0]  tmf_reg, tmf_next;
    logic        inv_reg, inv_next;

    logic        accept;
    logic        has_job;
    logic [7:0]  c;
    logic [1:0]  pos_e, cnt_e;
    logic [23:0] ins_e, bits_e;
    logic        is_space, is_pad;
    logic [6:0]  dec_code;
    logic [5:0]  sextet_v;
    logic [23:0] ins_d, bits_d;
    logic [2:0]  n_d;
    logic        pad_d, inv_d;

    assign item.ready = !q_full;
    assign accept     = item.valid && !q_full;
    assign c          = item.data_byte;
    assign job_push   = accept && has_job;

    always_comb
    begin
        gb_next  = gb_reg;
        gc_next  = gc_reg;
        pad_next = pad_reg;
        tmf_next = tmf_reg;
        inv_next = inv_reg;
        job      = '0;
        has_job  = 1'b0;

        // encode: byte position, saturating at the third slot
        pos_e = (gc_reg == 2'd3) ? 2'd2 : gc_reg;
        cnt_e = pos_e + 2'd1;
        case (pos_e)
            2'd0:    ins_e = {c, 16'h0000};
            2'd1:    ins_e = {8'h00, c, 8'h00};
            default: ins_e = {16'h0000, c};
        endcase
        bits_e = gb_reg | ins_e;

        // decode: classify and place the sextet
        is_space = (c == b64_pkg::CHAR_SPACE) || (c == b64_pkg::CHAR_CR)
                   || (c == b64_pkg::CHAR_LF);
        is_pad   = (c == b64_pkg::CHAR_PAD);
        dec_code = b64_pkg::char_sextet(c, alphabet_variant);
        sextet_v = dec_code[6] ? 6'h3F : dec_code[5:0];
        case (tmf_reg)
            2'd0:    ins_d = {sextet_v, 18'h0};
            2'd1:    ins_d = {6'h00, sextet_v, 12'h000};
            2'd2:    ins_d = {12'h000, sextet_v, 6'h00};
            default: ins_d = {18'h0, sextet_v};
        endcase
        n_d    = {1'b0, gc_reg};
        bits_d = gb_reg;
        pad_d  = pad_reg;
        inv_d  = inv_reg;
        if (!pad_reg)
        begin
            if (is_pad)
            begin
                pad_d = 1'b1;
            end
            else
            begin
                inv_d  = inv_reg | dec_code[6];
                bits_d = gb_reg | ins_d;
                n_d    = n_d + 3'd1;
            end
        end

        if (!item.action)
        begin
            for (int i = 0; i < b64_pkg::JOB_MAX_BYTES; i++)
            begin
                job.bytes[i] = ((cnt_e == 2'd3) || (3'(i) <= {1'b0, cnt_e}))
                    ? b64_pkg::sextet_char(bits_e[23-6*i -: 6], alphabet_variant)
                    : b64_pkg::CHAR_PAD;
            end
            job.status = b64_pkg::STATUS_OK;
            if ((cnt_e == 2'd3) || item.last_item)
            begin
                job.count = 3'd4;
                has_job   = 1'b1;
                gb_next   = '0;
                gc_next   = '0;
                pad_next  = 1'b0;
                tmf_next  = '0;
                inv_next  = 1'b0;
            end
            else
            begin
                gc_next = cnt_e;
                gb_next = bits_e;
            end
        end
        else
        begin
            if (!is_space)
            begin
                gb_next  = bits_d;
                gc_next  = n_d[1:0];
                pad_next = pad_d;
                tmf_next = tmf_reg + 2'd1;
                inv_next = inv_d;
                if (tmf_reg == 2'd3)
                begin
                    job.status = inv_d ? b64_pkg::STATUS_INVALID : b64_pkg::STATUS_OK;
                    for (int i = 0; i < 3; i++)
                    begin
                        job.bytes[i] = bits_d[23-8*i -: 8];
                    end
                    if (n_d >= 3'd2)
                    begin
                        job.count = n_d - 3'd1;
                        has_job   = 1'b1;
                    end
                    else if (inv_d)
                    begin
                        job.bytes[0] = 8'h00;
                        job.count    = 3'd1;
                        has_job      = 1'b1;
                    end
                    gb_next  = '0;
                    gc_next  = '0;
                    pad_next = 1'b0;
                    tmf_next = '0;
                    inv_next = 1'b0;
                end
            end
            if (item.last_item)
            begin
                // end of message: report leftover characters as a length error, then clear the group
                if (tmf_next != 2'd0)
                begin
                    job.bytes  = '0;
                    job.count  = 3'd1;
                    job.status = b64_pkg::STATUS_BAD_LEN;
                    has_job    = 1'b1;
                end
                gb_next  = '0;
                gc_next  = '0;
                pad_next = 1'b0;
                tmf_next = '0;
                inv_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gb_reg  <= '0;
            gc_reg  <= '0;
            pad_reg <= 1'b0;
            tmf_reg <= '0;
            inv_reg <= 1'b0;
        end
        else if (accept)
        begin
            gb_reg  <= gb_next;
            gc_reg  <= gc_next;
            pad_reg <= pad_next;
            tmf_reg <= tmf_next;
            inv_reg <= inv_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/b64_job_q.sv */
// small job queue between front end and serializer
`default_nettype none

module b64_job_q #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire b64_pkg::job_t wr_data,
    output logic               full,
    input  wire logic          pop,
    output b64_pkg::job_t      rd_data,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

/* rtl/core/b64_back.sv */
// back end: serializes queued jobs into result beats
`default_nettype none

module b64_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire b64_pkg::job_t head,
    input  wire logic          empty,
    output logic               pop,
    b64_result_if.source       result
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [1:0] status_reg;
    logic       load;
    logic       at_end;

    assign load   = !empty && (!valid_reg || result.ready);
    assign at_end = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign pop    = load && at_end;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= head.bytes[idx_reg];
            last_reg   <= at_end;
            status_reg <= head.status;
        end
    end

    assign result.valid    = valid_reg;
    assign result.out_byte = byte_reg;
    assign result.run_last = last_reg;
    assign result.status   = status_reg;

endmodule

`default_nettype wire

/* rtl/core/base64_stream_codec.sv */
// top level of the streaming base64 encoder / decoder
// path: with an idle back end, the job of an input beat is written into the queue,
//   then the back end loads its first byte into the output register and raises valid
// throughput: one input beat per cycle while the job queue has room, one result beat out
//   per cycle while ready is high; the serializer paces it (four beats per encode group)
// reset: rst_n clears group state, the queue, the output valid flag and selects the
//   standard alphabet
`default_nettype none

module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    b64_cfg_if.sink   cfg,
    b64_item_if.sink  item,
    b64_result_if.source result
);

    // alphabet select, to be written only while the codec is idle; the block itself does not enforce this
    logic alphabet_reg, alphabet_next;

    // front to queue
    b64_pkg::job_t job;
    logic          job_push;
    logic          q_full;

    // queue to back
    b64_pkg::job_t head;
    logic          q_empty;
    logic          q_pop;

    assign cfg.ready     = 1'b1;
    assign alphabet_next = (cfg.valid) ? cfg.alphabet_variant : alphabet_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alphabet_reg <= 1'b0;
        else
            alphabet_reg <= alphabet_next;
    end

    // front end: classify the beat, update group state, build the job
    b64_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .alphabet_variant (alphabet_reg),
        .q_full           (q_full),
        .item             (item),
        .job              (job),
        .job_push         (job_push)
    );

    // decoupling queue, lets the front keep taking beats while results drain
    b64_job_q #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wr_data (job),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (head),
        .empty   (q_empty)
    );

    // back end: one result beat per cycle from the head job while the result side is ready
    b64_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (q_empty),
        .pop    (q_pop),
        .result (result)
    );

    // a job never goes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !q_full)
        else $error("job pushed into full queue");

    // every pushed job carries one to four result bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.count != 3'd0 && job.count <= 3'd4))
        else $error("job with bad result count");

    // a length error is a lone zero beat closing its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == b64_pkg::STATUS_BAD_LEN)
        |-> (result.out_byte == 8'h00 && result.run_last))
        else $error("bad length beat malformed");

    // the head job is only popped from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* tb/base64_stream_codec_tb.sv */
// self-checking testbench for the streaming base64 codec with a mirrored codec and beat checker

module base64_stream_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64_pkg::*;

    // item action codes
    localparam bit ACT_ENCODE = 1'b0;
    localparam bit ACT_DECODE = 1'b1;

    // marker for a character outside the alphabet
    localparam logic [6:0] SEXTET_NONE = 7'd64;

    // run shape
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 75;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT  = 2000;

    // one result beat as the block should present it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic [1:0] status;
    } result_beat_t;

    // mirror of the codec state plus the queue of beats still owed by the block
    class codec_mirror;
        bit           variant;
        logic [23:0]  grp_bits;
        logic [1:0]   grp_count;
        bit           pad_hit;
        logic [1:0]   quad_pos;
        bit           bad_char;
        result_beat_t due_beats[$];
        int           mismatches;
        string        letters62 =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

        function void clear_group();
            grp_bits  = '0;
            grp_count = '0;
            pad_hit   = 1'b0;
            quad_pos  = '0;
            bad_char  = 1'b0;
        endfunction

        function logic [7:0] glyph(int v);
            if (v < 62)
                return letters62[v];
            if (v == 62)
                return variant ? "-" : "+";
            return variant ? "_" : "/";
        endfunction

        function logic [6:0] sextet_of(logic [7:0] c);
            for (int i = 0; i < 64; i++)
                if (glyph(i) == c)
                    return 7'(i);
            return SEXTET_NONE;
        endfunction

        function void owe(ref result_beat_t fresh[$], input logic [7:0] b, input logic [1:0] st);
            result_beat_t r;
            r.out_byte = b;
            r.run_last = 1'b0;
            r.status   = st;
            fresh.push_back(r);
        endfunction

        // works out the beats that one accepted item causes and queues them
        function void absorb_item(bit act, logic [7:0] c, bit fin);
            result_beat_t fresh[$];
            logic [23:0]  sh;
            logic [6:0]   v;
            logic [1:0]   st;
            int           p;
            int           cnt;
            int           n;
            if (act == ACT_ENCODE) begin
                p   = (grp_count > 2'd2) ? 2 : int'(grp_count);
                cnt = p + 1;
                grp_bits = grp_bits | ({16'h0, c} << (8 * (2 - p)));
                if (cnt == 3) begin
                    for (int i = 0; i < 4; i++) begin
                        sh = grp_bits >> (6 * (3 - i));
                        owe(fresh, glyph(int'(sh[5:0])), STATUS_OK);
                    end
                    clear_group();
                end else begin
                    grp_count = 2'(cnt);
                    if (fin) begin
                        for (int i = 0; i <= cnt; i++) begin
                            sh = grp_bits >> (6 * (3 - i));
                            owe(fresh, glyph(int'(sh[5:0])), STATUS_OK);
                        end
                        for (int i = cnt; i < 3; i++)
                            owe(fresh, CHAR_PAD, STATUS_OK);
                    end
                end
                if (fin)
                    clear_group();
            end else begin
                if (c != CHAR_SPACE && c != CHAR_CR && c != CHAR_LF) begin
                    p = int'(quad_pos);
                    n = int'(grp_count);
                    if (!pad_hit) begin
                        if (c == CHAR_PAD) begin
                            pad_hit = 1'b1;
                        end else begin
                            v = sextet_of(c);
                            if (v == SEXTET_NONE) begin
                                bad_char = 1'b1;
                                v = 7'd63;
                            end
                            grp_bits = grp_bits | ({18'h0, v[5:0]} << (6 * (3 - p)));
                            n = n + 1;
                        end
                    end
                    grp_count = 2'(n);
                    quad_pos  = 2'(p + 1);
                    if (p == 3) begin
                        st = bad_char ? STATUS_INVALID : STATUS_OK;
                        if (n >= 2) begin
                            for (int i = 0; i + 1 < n; i++) begin
                                sh = grp_bits >> (8 * (2 - i));
                                owe(fresh, sh[7:0], st);
                            end
                        end else if (bad_char) begin
                            owe(fresh, 8'h00, STATUS_INVALID);
                        end
                        clear_group();
                    end
                end
                if (fin) begin
                    if (quad_pos != 2'd0)
                        owe(fresh, 8'h00, STATUS_BAD_LEN);
                    clear_group();
                end
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].run_last = 1'b1;
            foreach (fresh[i])
                due_beats.push_back(fresh[i]);
        endfunction

        task note_mismatch(string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        task match_result(logic [7:0] b, logic rl, logic [1:0] st);
            result_beat_t want;
            if (due_beats.size() == 0) begin
                note_mismatch($sformatf("unexpected beat byte %h run_last %b status %0d",
                                        b, rl, st));
            end else begin
                want = due_beats.pop_front();
                if (b !== want.out_byte)
                    note_mismatch($sformatf("out_byte %h, want %h", b, want.out_byte));
                if (rl !== want.run_last)
                    note_mismatch($sformatf("run_last %b, want %b", rl, want.run_last));
                if (st !== want.status)
                    note_mismatch($sformatf("status %0d, want %0d", st, want.status));
            end
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    b64_cfg_if    cfg_bus ();
    b64_item_if   item_bus ();
    b64_result_if result_bus ();

    codec_mirror mirror;

    int quiet_cycles = 0;
    int items_sent   = 0;
    bit no_gaps      = 1'b0;

    base64_stream_codec u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    always #5 clk = ~clk;

    // any handshake on any channel counts as progress for the watchdog
    wire beat_moved = (item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
                      (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) ||
                      (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1);

    // mostly no gap, often a short one, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one input beat: optional gap, then hold valid until the block takes it
    task automatic send_item(bit act, logic [7:0] b, bit fin);
        int gap;
        gap = no_gaps ? 0 : idle_cycles();
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.action    <= act;
        item_bus.data_byte <= b;
        item_bus.last_item <= fin;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        mirror.absorb_item(act, b, fin);
        // skipped whitespace does not count toward the item budget
        if (!(act == ACT_DECODE && !fin &&
              (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_LF)))
            items_sent++;
    endtask

    task automatic send_text(bit act, string s, bit fin);
        for (int i = 0; i < s.len(); i++)
            send_item(act, s[i], fin && (i == s.len() - 1));
    endtask

    // drop valid and wait for every owed beat to come out
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (mirror.due_beats.size() != 0)
            @(posedge clk);
    endtask

    // register write only once the block has gone quiet
    task automatic write_alphabet(bit v);
        drain_results();
        // an item with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_bus.valid            <= 1'b1;
        cfg_bus.alphabet_variant <= v;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        mirror.variant = v;
        cfg_bus.valid <= 1'b0;
    endtask

    // raw bytes with the extremes favored, closed by last_item
    task automatic send_raw_message();
        int         len;
        int         r;
        logic [7:0] b;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 7);
            b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            send_item(ACT_ENCODE, b, i == len - 1);
        end
    endtask

    // well-formed base64 text with random content, sometimes spoiled
    task automatic send_b64_message();
        logic [7:0] text[$];
        int         groups;
        int         pads;
        int         spot;
        int         r;
        bit         fin;
        groups = $urandom_range(1, 3);
        pads   = $urandom_range(0, 2);
        for (int g = 0; g < groups; g++)
            for (int k = 0; k < 4; k++)
                if (g == groups - 1 && k >= 4 - pads)
                    text.push_back(CHAR_PAD);
                else
                    text.push_back(mirror.glyph($urandom_range(0, 63)));
        r = $urandom_range(0, 11);
        if (r == 0) begin
            // stray byte somewhere in the text
            spot = $urandom_range(0, text.size() - 1);
            text[spot] = 8'($urandom_range(0, 255));
        end else if (r == 1) begin
            // lost character, so the length goes bad
            spot = $urandom_range(0, text.size() - 1);
            text.delete(spot);
        end
        // sprinkle whitespace between characters
        for (int i = text.size() - 1; i > 0; i--)
            if ($urandom_range(0, 11) == 0)
                text.insert(i, ($urandom_range(0, 2) == 0) ? CHAR_SPACE :
                               ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF);
        if ($urandom_range(0, 4) == 0)
            text.push_back(CHAR_LF);
        fin = ($urandom_range(0, 7) != 0);
        foreach (text[i])
            send_item(ACT_DECODE, text[i], fin && (i == text.size() - 1));
    endtask

    // random actions and bytes, leaning on the interesting characters
    task automatic send_noise();
        logic [7:0] picks[11];
        logic [7:0] b;
        int         len;
        picks = '{CHAR_PAD, CHAR_SPACE, CHAR_CR, CHAR_LF, "+", "/", "-", "_", "A", "z", "0"};
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                     : picks[$urandom_range(0, 10)];
            send_item(1'($urandom_range(0, 1)), b,
                      (i == len - 1) || ($urandom_range(0, 3) == 0));
        end
    endtask

    // reset and stimulus
    initial begin
        int kind;
        int budget;
        mirror = new;
        mirror.clear_group();
        cfg_bus.valid            <= 1'b0;
        cfg_bus.alphabet_variant <= 1'b0;
        item_bus.valid           <= 1'b0;
        item_bus.action          <= ACT_ENCODE;
        item_bus.data_byte       <= 8'h00;
        item_bus.last_item       <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: standard alphabet
        write_alphabet(1'b0);
        // full group from the byte extremes, then flushes of one and two bytes
        send_item(ACT_ENCODE, 8'h00, 1'b0);
        send_item(ACT_ENCODE, 8'hFF, 1'b0);
        send_item(ACT_ENCODE, 8'hFB, 1'b1);
        send_item(ACT_ENCODE, 8'hFB, 1'b1);
        send_text(ACT_ENCODE, "Ma", 1'b1);
        // whitespace inside a group, one pad, end flag on a skipped character
        send_text(ACT_DECODE, "+\n/A=\015", 1'b1);
        // invalid character, and a character after the pad left alone
        send_text(ACT_DECODE, "*Q=x", 1'b0);
        // short group that only carries the invalid flag
        send_text(ACT_DECODE, "!===", 1'b0);

        // directed: url-safe alphabet
        write_alphabet(1'b1);
        send_text(ACT_DECODE, "-_8=", 1'b0);
        send_item(ACT_ENCODE, 8'hFB, 1'b0);
        send_item(ACT_ENCODE, 8'hFF, 1'b0);
        send_item(ACT_ENCODE, 8'hFF, 1'b1);
        // bad length wins over invalid, ended on a skipped character
        send_text(ACT_DECODE, "A!\n", 1'b1);

        // random phases, each under its own alphabet
        for (int phase = 0; phase < PHASES; phase++) begin
            write_alphabet((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
            budget = items_sent + PHASE_ITEMS;
            while (items_sent < budget) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                // sender holds off until the block has caught up
                if ((phase == 2 && items_sent + PHASE_ITEMS == budget) ||
                    $urandom_range(0, 15) == 0)
                    drain_results();
                kind = $urandom_range(0, 9);
                if (kind < 4)
                    send_raw_message();
                else if (kind < 8)
                    send_b64_message();
                else
                    send_noise();
            end
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.due_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: ready runs with random stalls, some long stall-free stretches
    initial begin
        int run;
        int stall;
        result_bus.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 20);
            result_bus.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_cycles();
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // every accepted result beat is checked against the oldest owed beat
    always @(posedge clk) begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            mirror.match_result(result_bus.out_byte, result_bus.run_last, result_bus.status);
    end

    // stop a hung run
    always @(posedge clk) begin
        if (!rst_n || beat_moved)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
